[rtl/eacr_pkg.sv]
package eacr_pkg;

    localparam int CW = 36;
    localparam int MW = 32;

    localparam logic signed [CW-1:0] Q30_ONE     = 36'sh0_4000_0000;
    localparam logic signed [CW-1:0] HALF_TURN   = 36'sh0_8000_0000;
    localparam logic signed [CW-1:0] SC_GAIN     = 36'sd652032874;
    localparam logic signed [MW-1:0] M_ONE       = 32'sh4000_0000;
    localparam logic [31:0]          POLE_LIMIT  = 32'd10737;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_LOAD,
        DP_SC_INIT,
        DP_CORDIC,
        DP_SC_END,
        DP_RD_X,
        DP_RD_Y,
        DP_MUL,
        DP_MUL_ACC,
        DP_SUM,
        DP_WR,
        DP_SQ_INIT,
        DP_SQ_STEP,
        DP_AT_INIT,
        DP_AT_END,
        DP_YAW_ZERO,
        DP_OUT
    } dp_op_t;

    typedef enum logic [1:0] {
        OPND_C,
        OPND_S,
        OPND_X,
        OPND_Y
    } opnd_t;

    typedef enum logic [1:0] {
        TGT_PIT,
        TGT_YAW,
        TGT_ROL
    } tgt_t;

    typedef struct packed {
        dp_op_t     op;
        opnd_t      mul_a;
        opnd_t      mul_b;
        logic       sub;
        logic [1:0] row;
        logic [1:0] col;
        logic [2:0] rot;
        logic [4:0] idx;
        logic       sin_mode;
        logic       neg_y;
        logic       use_horiz;
        tgt_t       tgt;
    } dp_cmd_t;

    typedef struct packed {
        logic zero_step;
        logic pole;
        logic at_stop;
    } dp_stat_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_SC_INIT,
        S_SC_ITER,
        S_SC_END,
        S_RD_X,
        S_RD_Y,
        S_M1,
        S_M2,
        S_ADD,
        S_WRP,
        S_M3,
        S_M4,
        S_SUB,
        S_WRQ,
        S_SQ_RDX,
        S_SQ_RDY,
        S_SQ_M1,
        S_SQ_M2,
        S_SQ_ADD,
        S_SQ_INIT,
        S_SQ_ITER,
        S_AT_RDY,
        S_AT_RDX,
        S_AT_INIT,
        S_AT_ITER,
        S_AT_END,
        S_FINISH
    } ctrl_state_t;

    // Rotation axis of each of the five local rotations.
    function automatic logic [1:0] rot_axis(input logic [2:0] rot);
        logic [1:0] a;
        case (rot)
            3'd0:    a = 2'd1;
            3'd1:    a = 2'd0;
            3'd2:    a = 2'd2;
            3'd3:    a = 2'd1;
            default: a = 2'd0;
        endcase
        return a;
    endfunction

    function automatic logic [1:0] mod3_inc(input logic [1:0] v);
        return (v == 2'd2) ? 2'd0 : v + 2'd1;
    endfunction

    // Arctangent of 2^-i in units of 2^32 per turn.
    function automatic logic signed [CW-1:0] arc_angle(input logic [4:0] i);
        logic signed [CW-1:0] a;
        case (i)
            5'd0:    a = 36'sh020000000;
            5'd1:    a = 36'sh012e4051e;
            5'd2:    a = 36'sh009fb385b;
            5'd3:    a = 36'sh0051111d4;
            5'd4:    a = 36'sh0028b0d43;
            5'd5:    a = 36'sh00145d7e1;
            5'd6:    a = 36'sh000a2f61e;
            5'd7:    a = 36'sh000517c55;
            5'd8:    a = 36'sh00028be53;
            5'd9:    a = 36'sh000145f2f;
            5'd10:   a = 36'sh0000a2f98;
            5'd11:   a = 36'sh0000517cc;
            5'd12:   a = 36'sh000028be6;
            5'd13:   a = 36'sh0000145f3;
            5'd14:   a = 36'sh00000a2fa;
            5'd15:   a = 36'sh00000517d;
            5'd16:   a = 36'sh0000028be;
            5'd17:   a = 36'sh00000145f;
            5'd18:   a = 36'sh000000a30;
            5'd19:   a = 36'sh000000518;
            5'd20:   a = 36'sh00000028c;
            5'd21:   a = 36'sh000000146;
            5'd22:   a = 36'sh0000000a3;
            5'd23:   a = 36'sh000000051;
            5'd24:   a = 36'sh000000029;
            5'd25:   a = 36'sh000000014;
            5'd26:   a = 36'sh00000000a;
            5'd27:   a = 36'sh000000005;
            5'd28:   a = 36'sh000000003;
            5'd29:   a = 36'sh000000001;
            5'd30:   a = 36'sh000000001;
            default: a = '0;
        endcase
        return a;
    endfunction

    // Signed shift right that truncates toward zero.
    function automatic logic signed [CW-1:0] tdiv(input logic signed [CW-1:0] v,
                                                  input logic [4:0] sh);
        logic signed [CW-1:0] r;
        if (v[CW-1])
        begin
            r = -((-v) >>> sh);
        end
        else
        begin
            r = v >>> sh;
        end
        return r;
    endfunction

endpackage

[rtl/eacr_ctrl.sv]
module eacr_ctrl
    import eacr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    ctrl_state_t state_reg, state_next;
    logic [4:0]  i_reg, i_next;
    logic [1:0]  k_reg, k_next;
    logic [2:0]  rot_reg, rot_next;
    logic [1:0]  aj_reg, aj_next;
    logic        out_valid_reg, out_valid_next;
    logic [1:0]  axis, p_row, q_row;

    assign axis  = rot_axis(rot_reg);
    assign p_row = mod3_inc(axis);
    assign q_row = mod3_inc(p_row);

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            i_reg         <= '0;
            k_reg         <= '0;
            rot_reg       <= '0;
            aj_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            k_reg         <= k_next;
            rot_reg       <= rot_next;
            aj_reg        <= aj_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        k_next         = k_reg;
        rot_next       = rot_reg;
        aj_next        = aj_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.op         = DP_NOP;
        cmd.rot        = rot_reg;
        cmd.idx        = i_reg;
        cmd.col        = k_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = DP_LOAD;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                rot_next   = '0;
                state_next = stat.zero_step ? S_FINISH : S_SC_INIT;
            end
            S_SC_INIT:
            begin
                cmd.op     = DP_SC_INIT;
                i_next     = '0;
                state_next = S_SC_ITER;
            end
            S_SC_ITER:
            begin
                cmd.op       = DP_CORDIC;
                cmd.sin_mode = 1'b1;
                if (i_reg == 5'd30)
                begin
                    state_next = S_SC_END;
                end
                else
                begin
                    i_next = i_reg + 5'd1;
                end
            end
            S_SC_END:
            begin
                cmd.op     = DP_SC_END;
                k_next     = '0;
                state_next = S_RD_X;
            end
            S_RD_X:
            begin
                cmd.op     = DP_RD_X;
                cmd.row    = p_row;
                state_next = S_RD_Y;
            end
            S_RD_Y:
            begin
                cmd.op     = DP_RD_Y;
                cmd.row    = q_row;
                state_next = S_M1;
            end
            S_M1:
            begin
                cmd.op     = DP_MUL;
                cmd.mul_a  = OPND_C;
                cmd.mul_b  = OPND_X;
                state_next = S_M2;
            end
            S_M2:
            begin
                cmd.op     = DP_MUL_ACC;
                cmd.mul_a  = OPND_S;
                cmd.mul_b  = OPND_Y;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                cmd.op     = DP_SUM;
                state_next = S_WRP;
            end
            S_WRP:
            begin
                cmd.op     = DP_WR;
                cmd.row    = p_row;
                state_next = S_M3;
            end
            S_M3:
            begin
                cmd.op     = DP_MUL;
                cmd.mul_a  = OPND_C;
                cmd.mul_b  = OPND_Y;
                state_next = S_M4;
            end
            S_M4:
            begin
                cmd.op     = DP_MUL_ACC;
                cmd.mul_a  = OPND_S;
                cmd.mul_b  = OPND_X;
                state_next = S_SUB;
            end
            S_SUB:
            begin
                cmd.op     = DP_SUM;
                cmd.sub    = 1'b1;
                state_next = S_WRQ;
            end
            S_WRQ:
            begin
                cmd.op  = DP_WR;
                cmd.row = q_row;
                if (k_reg == 2'd2)
                begin
                    if (rot_reg == 3'd4)
                    begin
                        state_next = S_SQ_RDX;
                    end
                    else
                    begin
                        rot_next   = rot_reg + 3'd1;
                        state_next = S_SC_INIT;
                    end
                end
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = S_RD_X;
                end
            end
            S_SQ_RDX:
            begin
                cmd.op     = DP_RD_X;
                cmd.row    = 2'd2;
                cmd.col    = 2'd2;
                state_next = S_SQ_RDY;
            end
            S_SQ_RDY:
            begin
                cmd.op     = DP_RD_Y;
                cmd.row    = 2'd2;
                cmd.col    = 2'd0;
                state_next = S_SQ_M1;
            end
            S_SQ_M1:
            begin
                cmd.op     = DP_MUL;
                cmd.mul_a  = OPND_X;
                cmd.mul_b  = OPND_X;
                state_next = S_SQ_M2;
            end
            S_SQ_M2:
            begin
                cmd.op     = DP_MUL_ACC;
                cmd.mul_a  = OPND_Y;
                cmd.mul_b  = OPND_Y;
                state_next = S_SQ_ADD;
            end
            S_SQ_ADD:
            begin
                cmd.op     = DP_SUM;
                state_next = S_SQ_INIT;
            end
            S_SQ_INIT:
            begin
                cmd.op     = DP_SQ_INIT;
                i_next     = '0;
                state_next = S_SQ_ITER;
            end
            S_SQ_ITER:
            begin
                cmd.op = DP_SQ_STEP;
                if (i_reg == 5'd31)
                begin
                    aj_next    = '0;
                    state_next = S_AT_RDY;
                end
                else
                begin
                    i_next = i_reg + 5'd1;
                end
            end
            S_AT_RDY:
            begin
                if (aj_reg == 2'd1 && stat.pole)
                begin
                    // Near the pole the yaw is forced to zero.
                    cmd.op  = DP_YAW_ZERO;
                    aj_next = 2'd2;
                end
                else
                begin
                    cmd.op     = DP_RD_Y;
                    state_next = S_AT_RDX;
                    if (aj_reg == 2'd0)
                    begin
                        cmd.row = 2'd2;
                        cmd.col = 2'd1;
                    end
                    else if (aj_reg == 2'd1)
                    begin
                        cmd.row = 2'd2;
                        cmd.col = 2'd0;
                    end
                    else if (stat.pole)
                    begin
                        cmd.row = 2'd1;
                        cmd.col = 2'd0;
                    end
                    else
                    begin
                        cmd.row = 2'd0;
                        cmd.col = 2'd1;
                    end
                end
            end
            S_AT_RDX:
            begin
                state_next = S_AT_INIT;
                if (aj_reg != 2'd0)
                begin
                    cmd.op = DP_RD_X;
                    if (aj_reg == 2'd1)
                    begin
                        cmd.row = 2'd2;
                        cmd.col = 2'd2;
                    end
                    else if (stat.pole)
                    begin
                        cmd.row = 2'd0;
                        cmd.col = 2'd0;
                    end
                    else
                    begin
                        cmd.row = 2'd1;
                        cmd.col = 2'd1;
                    end
                end
            end
            S_AT_INIT:
            begin
                cmd.op        = DP_AT_INIT;
                cmd.neg_y     = (aj_reg == 2'd0) || (aj_reg == 2'd2 && stat.pole);
                cmd.use_horiz = (aj_reg == 2'd0);
                i_next        = '0;
                state_next    = S_AT_ITER;
            end
            S_AT_ITER:
            begin
                if (stat.at_stop || i_reg == 5'd31)
                begin
                    state_next = S_AT_END;
                end
                else
                begin
                    cmd.op = DP_CORDIC;
                    i_next = i_reg + 5'd1;
                end
            end
            S_AT_END:
            begin
                cmd.op = DP_AT_END;
                case (aj_reg)
                    2'd0:    cmd.tgt = TGT_PIT;
                    2'd1:    cmd.tgt = TGT_YAW;
                    default: cmd.tgt = TGT_ROL;
                endcase
                if (aj_reg == 2'd2)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    aj_next    = aj_reg + 2'd1;
                    state_next = S_AT_RDY;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = DP_OUT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/eacr_dp.sv]
module eacr_dp
    import eacr_pkg::*;
(
    input  logic        clk,
    input  logic [15:0] cur_yaw,
    input  logic [15:0] cur_pitch,
    input  logic [15:0] cur_roll,
    input  logic [15:0] pitch_step,
    input  logic [15:0] yaw_step_neg,
    input  dp_cmd_t     cmd,
    output dp_stat_t    stat,
    output logic [15:0] new_yaw,
    output logic [15:0] new_pitch,
    output logic [15:0] new_roll
);

    logic [15:0]             yaw0_reg, pit0_reg, rol0_reg, dp_reg, dyn_reg;
    logic signed [MW-1:0]    m_reg [9];
    logic signed [MW-1:0]    x_reg, y_reg, s_reg, c_reg;
    logic signed [2*MW-1:0]  prod_reg, acc_reg, sum_reg;
    logic signed [CW-1:0]    cx_reg, cy_reg, cph_reg;
    logic [15:0]             ang_reg;
    logic                    flip_reg, stop_reg;
    logic [63:0]             v_reg, r_reg;
    logic signed [CW-1:0]    pit_reg, yaw_reg, rol_reg;
    logic [15:0]             oy_reg, op_reg, or_reg;

    logic [3:0]              midx;
    logic signed [MW-1:0]    m_rd, mul_a, mul_b;
    logic [15:0]             ang;
    logic signed [CW-1:0]    ph0, dx, dy, arc, at_x, at_y;
    logic                    rot_pos;
    logic [63:0]             sq_b, sq_t;
    logic [5:0]              sq_sh;

    function automatic logic signed [MW-1:0] round_q30(input logic signed [63:0] v);
        logic signed [63:0] r;
        if (v[63])
        begin
            r = -(((-v) + 64'sd536870912) >>> 30);
        end
        else
        begin
            r = (v + 64'sd536870912) >>> 30;
        end
        return r[MW-1:0];
    endfunction

    function automatic logic [15:0] round_angle(input logic signed [CW-1:0] a);
        logic signed [CW-1:0] r;
        if (a[CW-1])
        begin
            r = -(((-a) + 36'sd32768) >>> 16);
        end
        else
        begin
            r = (a + 36'sd32768) >>> 16;
        end
        return r[15:0];
    endfunction

    function automatic logic signed [MW-1:0] pick(input opnd_t o,
                                                  input logic signed [MW-1:0] c,
                                                  input logic signed [MW-1:0] s,
                                                  input logic signed [MW-1:0] x,
                                                  input logic signed [MW-1:0] y);
        logic signed [MW-1:0] r;
        case (o)
            OPND_C:  r = c;
            OPND_S:  r = s;
            OPND_X:  r = x;
            default: r = y;
        endcase
        return r;
    endfunction

    assign midx  = 4'(cmd.row) * 4'd3 + 4'(cmd.col);
    assign m_rd  = m_reg[midx];
    assign mul_a = pick(cmd.mul_a, c_reg, s_reg, x_reg, y_reg);
    assign mul_b = pick(cmd.mul_b, c_reg, s_reg, x_reg, y_reg);

    always_comb
    begin
        case (cmd.rot)
            3'd0:    ang = 16'h0000 - yaw0_reg;
            3'd1:    ang = 16'hc000 - pit0_reg;
            3'd2:    ang = 16'h0000 - rol0_reg;
            3'd3:    ang = 16'h0000 - dyn_reg;
            default: ang = dp_reg;
        endcase
    end

    assign ph0     = {{4{ang[15]}}, ang, 16'h0000};
    assign dx      = tdiv(cy_reg, cmd.idx);
    assign dy      = tdiv(cx_reg, cmd.idx);
    assign arc     = arc_angle(cmd.idx);
    assign rot_pos = cmd.sin_mode ? !cph_reg[CW-1] : (cy_reg <= 0);
    assign at_y    = cmd.neg_y ? -CW'(y_reg) : CW'(y_reg);
    assign at_x    = cmd.use_horiz ? {4'b0000, r_reg[31:0]} : CW'(x_reg);
    assign sq_sh   = 6'd62 - {cmd.idx, 1'b0};
    assign sq_b    = 64'd1 << sq_sh;
    assign sq_t    = r_reg + sq_b;

    assign stat.zero_step = (dp_reg == 16'h0000) && (dyn_reg == 16'h0000);
    assign stat.pole      = !(r_reg[31:0] > POLE_LIMIT) || (r_reg[63:32] != 32'h0) == 1'b0
                            && !(r_reg[31:0] > POLE_LIMIT);
    assign stat.at_stop   = stop_reg || (cy_reg == 0);

    assign new_yaw   = oy_reg;
    assign new_pitch = op_reg;
    assign new_roll  = or_reg;

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            DP_LOAD:
            begin
                yaw0_reg <= cur_yaw;
                pit0_reg <= cur_pitch;
                rol0_reg <= cur_roll;
                dp_reg   <= pitch_step;
                dyn_reg  <= yaw_step_neg;
                for (int j = 0; j < 9; j++)
                begin
                    m_reg[j] <= (j == 0 || j == 4 || j == 8) ? M_ONE : '0;
                end
            end
            DP_SC_INIT:
            begin
                ang_reg <= ang;
                cx_reg  <= SC_GAIN;
                cy_reg  <= '0;
                if (ph0 > Q30_ONE)
                begin
                    cph_reg  <= ph0 - HALF_TURN;
                    flip_reg <= 1'b1;
                end
                else if (ph0 < -Q30_ONE)
                begin
                    cph_reg  <= ph0 + HALF_TURN;
                    flip_reg <= 1'b1;
                end
                else
                begin
                    cph_reg  <= ph0;
                    flip_reg <= 1'b0;
                end
            end
            DP_CORDIC:
            begin
                if (rot_pos)
                begin
                    cx_reg  <= cx_reg - dx;
                    cy_reg  <= cy_reg + dy;
                    cph_reg <= cph_reg - arc;
                end
                else
                begin
                    cx_reg  <= cx_reg + dx;
                    cy_reg  <= cy_reg - dy;
                    cph_reg <= cph_reg + arc;
                end
            end
            DP_SC_END:
            begin
                if (ang_reg[13:0] == 14'h0000)
                begin
                    // Exact values on multiples of a quarter turn.
                    s_reg <= (ang_reg == 16'h4000) ? M_ONE :
                             (ang_reg == 16'hc000) ? -M_ONE : '0;
                    c_reg <= (ang_reg == 16'h0000) ? M_ONE :
                             (ang_reg == 16'h8000) ? -M_ONE : '0;
                end
                else
                begin
                    s_reg <= flip_reg ? -cy_reg[MW-1:0] : cy_reg[MW-1:0];
                    c_reg <= flip_reg ? -cx_reg[MW-1:0] : cx_reg[MW-1:0];
                end
            end
            DP_RD_X:
            begin
                x_reg <= m_rd;
            end
            DP_RD_Y:
            begin
                y_reg <= m_rd;
            end
            DP_MUL:
            begin
                prod_reg <= mul_a * mul_b;
            end
            DP_MUL_ACC:
            begin
                acc_reg  <= prod_reg;
                prod_reg <= mul_a * mul_b;
            end
            DP_SUM:
            begin
                sum_reg <= cmd.sub ? acc_reg - prod_reg : acc_reg + prod_reg;
            end
            DP_WR:
            begin
                m_reg[midx] <= round_q30(sum_reg);
            end
            DP_SQ_INIT:
            begin
                v_reg <= sum_reg;
                r_reg <= '0;
            end
            DP_SQ_STEP:
            begin
                if (v_reg >= sq_t)
                begin
                    v_reg <= v_reg - sq_t;
                    r_reg <= (r_reg >> 1) + sq_b;
                end
                else
                begin
                    r_reg <= r_reg >> 1;
                end
            end
            DP_AT_INIT:
            begin
                stop_reg <= 1'b0;
                cx_reg   <= at_x;
                cy_reg   <= at_y;
                cph_reg  <= '0;
                if (at_y == 0)
                begin
                    cph_reg  <= at_x[CW-1] ? HALF_TURN : '0;
                    stop_reg <= 1'b1;
                end
                else if (at_x == 0)
                begin
                    cph_reg  <= at_y[CW-1] ? -Q30_ONE : Q30_ONE;
                    stop_reg <= 1'b1;
                end
                else if (at_x[CW-1])
                begin
                    cph_reg <= at_y[CW-1] ? -HALF_TURN : HALF_TURN;
                    cx_reg  <= -at_x;
                    cy_reg  <= -at_y;
                end
            end
            DP_AT_END:
            begin
                case (cmd.tgt)
                    TGT_PIT: pit_reg <= cph_reg;
                    TGT_YAW: yaw_reg <= cph_reg;
                    default: rol_reg <= cph_reg;
                endcase
            end
            DP_YAW_ZERO:
            begin
                yaw_reg <= '0;
            end
            DP_OUT:
            begin
                if (stat.zero_step)
                begin
                    oy_reg <= yaw0_reg;
                    op_reg <= pit0_reg;
                    or_reg <= rol0_reg;
                end
                else
                begin
                    oy_reg <= 16'h8000 - round_angle(yaw_reg);
                    op_reg <= 16'h4000 + round_angle(pit_reg);
                    or_reg <= 16'h8000 - round_angle(rol_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

[rtl/euler_angle_rotate_cordic.sv]
// Orientation update engine. Takes an orientation as yaw, pitch and roll
// binary angles (65536 per turn) together with a pitch change and a negated
// yaw change, and returns the updated yaw, pitch and roll.
// The input channel (in_valid/in_ready) moves one beat per orientation; the
// output channel (out_valid/out_ready) returns exactly one beat per input.
// One item is worked on at a time. When both changes are zero the angles are
// passed through unchanged. Otherwise a rotation matrix is built from five
// rotations, each computing sine and cosine by CORDIC and then multiplying
// and rounding over one shared 32x32 multiplier; then squaring and an
// integer square root follow, and up to three CORDIC arctangents (near the
// pole the yaw is forced to zero instead). The time an item takes is set
// by the serial CORDIC iterations and the shared multiplier.
// The finished result sits in an output register; in_ready rises again as
// soon as the result has moved there, so a new beat can be taken while the
// receiver stalls. A second result waits inside until the first is taken.
// Reset returns the controller to idle and clears out_valid; the block keeps
// no state between items.
module euler_angle_rotate_cordic
    import eacr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] cur_yaw,
    input  logic [15:0] cur_pitch,
    input  logic [15:0] cur_roll,
    input  logic [15:0] pitch_step,
    input  logic [15:0] yaw_step_neg,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] new_yaw,
    output logic [15:0] new_pitch,
    output logic [15:0] new_roll
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Controller: sequences the rotations, square root and arctangents.
    eacr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Datapath: matrix registers, shared CORDIC, multiplier and square root.
    eacr_dp u_dp (
        .clk          (clk),
        .cur_yaw      (cur_yaw),
        .cur_pitch    (cur_pitch),
        .cur_roll     (cur_roll),
        .pitch_step   (pitch_step),
        .yaw_step_neg (yaw_step_neg),
        .cmd          (cmd),
        .stat         (stat),
        .new_yaw      (new_yaw),
        .new_pitch    (new_pitch),
        .new_roll     (new_roll)
    );

endmodule
